// File: rtl/ceq_pkg.sv
// shared constants, codes and control/status structs of the coalescing event queue
// no dependencies; used by every module of the block
package ceq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int OP_W     = 3;
   localparam int CODE_W   = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 9;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   // request operations
   localparam logic [OP_W-1:0] OP_POST  = 3'd0;
   localparam logic [OP_W-1:0] OP_SEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_TAKE  = 3'd2;
   localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COALESCED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // latch an accepted request, restart the scan
      logic scan_step;  // one step of the queue search
      logic rd_head;    // read the head entry
      logic commit;     // update state and load the response register
   } ceq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_scan;  // request needs a search of the queue
      logic need_read;  // request needs the head entry
      logic match_now;  // entry under compare holds the code
      logic scan_done;  // search over with no match
   } ceq_stat_type;

endpackage

// File: rtl/coalescing_event_queue_top.sv
// Coalescing event queue: a first-in first-out queue of up to ceq_pkg::QUEUE_DEPTH events,
// each a code, a signed value and a handle. One request is worked at a time and gives one
// response. A send, clear, unknown operation or a post with a code out of range goes from
// dispatch straight to commit, a take also (after one registered read of the head entry);
// a flag post and a check search the queue from the head, one entry per cycle through the
// single read port of the entry memory, and stop early when a match ends the search. The
// next request is accepted in the cycle after the response is loaded, while it may still
// wait to be taken. The code limit register is written through the csr channel, which is
// always ready; it is to be written only while the queue is idle.
// Holds ceq_ctrl and ceq_datapath; depends on ceq_pkg.
module coalescing_event_queue_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ceq_pkg::OP_W-1:0]              req_operation,
   input  logic [ceq_pkg::CODE_W-1:0]            req_event_code,
   input  logic signed [ceq_pkg::DATA_W-1:0]     req_param_value,
   input  logic [ceq_pkg::DATA_W-1:0]            req_param_handle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ceq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ceq_pkg::CODE_W-1:0]            rsp_out_event,
   output logic signed [ceq_pkg::DATA_W-1:0]     rsp_out_value,
   output logic [ceq_pkg::DATA_W-1:0]            rsp_out_handle,
   output logic                                  rsp_finished,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ceq_pkg::LIMIT_W-1:0]           csr_event_code_limit
);

   ceq_pkg::ceq_cmd_type  cmd;
   ceq_pkg::ceq_stat_type stat;

   // limit register always takes a write
   assign csr_ready = 1'b1;

   // controller
   ceq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   ceq_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_event_code   (req_event_code),
      .req_param_value  (req_param_value),
      .req_param_handle (req_param_handle),
      .limit_wr         (csr_valid && csr_ready),
      .limit_data       (csr_event_code_limit),
      .rsp_status       (rsp_status),
      .rsp_out_event    (rsp_out_event),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_finished     (rsp_finished)
   );

endmodule

// File: rtl/ceq_ctrl.sv
// controller state machine of the coalescing event queue
// depends on ceq_pkg; drives commands to ceq_datapath
module ceq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ceq_pkg::ceq_stat_type stat,
   output ceq_pkg::ceq_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_DISPATCH = 4'b0010,
      S_SCAN     = 4'b0100,
      S_COMMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.rd_head   = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.need_scan) begin
               state_in = S_SCAN;
            end else begin
               cmd.rd_head = stat.need_read;
               state_in    = S_COMMIT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.match_now || stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid holds until taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/ceq_datapath.sv
// datapath of the coalescing event queue: entry memories, pointers, search and response
// depends on ceq_pkg; commanded by ceq_ctrl
module ceq_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ceq_pkg::ceq_cmd_type                  cmd,
   output ceq_pkg::ceq_stat_type                 stat,
   input  logic [ceq_pkg::OP_W-1:0]              req_operation,
   input  logic [ceq_pkg::CODE_W-1:0]            req_event_code,
   input  logic signed [ceq_pkg::DATA_W-1:0]     req_param_value,
   input  logic [ceq_pkg::DATA_W-1:0]            req_param_handle,
   input  logic                                  limit_wr,
   input  logic [ceq_pkg::LIMIT_W-1:0]           limit_data,
   output logic [ceq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ceq_pkg::CODE_W-1:0]            rsp_out_event,
   output logic signed [ceq_pkg::DATA_W-1:0]     rsp_out_value,
   output logic [ceq_pkg::DATA_W-1:0]            rsp_out_handle,
   output logic                                  rsp_finished
);

   localparam int SUM_W = ceq_pkg::CNT_W + 1;

   // entry memories
   logic [ceq_pkg::CODE_W-1:0] ev_mem  [ceq_pkg::QUEUE_DEPTH];
   logic [ceq_pkg::DATA_W-1:0] val_mem [ceq_pkg::QUEUE_DEPTH];
   logic [ceq_pkg::DATA_W-1:0] hdl_mem [ceq_pkg::QUEUE_DEPTH];

   // latched request
   logic [ceq_pkg::OP_W-1:0]   op_ff;
   logic [ceq_pkg::CODE_W-1:0] code_ff;
   logic [ceq_pkg::DATA_W-1:0] value_ff, handle_ff;

   // queue state
   logic [ceq_pkg::LIMIT_W-1:0] limit_ff;
   logic [ceq_pkg::IDX_W-1:0]   head_ff, tail_ff;
   logic [ceq_pkg::CNT_W-1:0]   count_ff;
   logic [ceq_pkg::CODE_W-1:0]  current_ff;

   // search state
   logic [ceq_pkg::CNT_W-1:0]   scan_ff;
   logic                        cmp_pend_ff;
   logic [ceq_pkg::IDX_W-1:0]   cmp_addr_ff;
   logic                        found_ff;
   logic [ceq_pkg::IDX_W-1:0]   pos_ff;

   // read data
   logic [ceq_pkg::CODE_W-1:0]  rd_ev_ff;
   logic [ceq_pkg::DATA_W-1:0]  rd_val_ff, rd_hdl_ff;

   // response register
   logic [ceq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ceq_pkg::CODE_W-1:0]   out_ev_ff, out_ev_in;
   logic [ceq_pkg::DATA_W-1:0]   out_val_ff, out_val_in;
   logic [ceq_pkg::DATA_W-1:0]   out_hdl_ff, out_hdl_in;
   logic                         fin_ff, fin_in;

   logic                        code_ok, full, empty, scan_more;
   logic [SUM_W-1:0]            scan_sum;
   logic [ceq_pkg::IDX_W-1:0]   scan_addr, rd_addr;
   logic                        rd_en;
   logic                        do_append, do_coalesce, do_take, do_clear;
   logic [ceq_pkg::IDX_W-1:0]   head_next, tail_next;

   // request decode
   assign code_ok = (code_ff != '0) && ({1'b0, code_ff} < limit_ff);
   assign full    = (count_ff == ceq_pkg::CNT_W'(ceq_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

   assign stat.need_scan = ((op_ff == ceq_pkg::OP_POST) && code_ok)
                           || (op_ff == ceq_pkg::OP_CHECK);
   assign stat.need_read = (op_ff == ceq_pkg::OP_TAKE) && !empty;
   assign stat.match_now = cmp_pend_ff && (rd_ev_ff == code_ff);
   assign stat.scan_done = !scan_more && !stat.match_now;

   // search address: head plus offset, wrapped
   assign scan_more = (scan_ff < count_ff);
   assign scan_sum  = SUM_W'(head_ff) + SUM_W'(scan_ff);
   always_comb begin
      if (scan_sum >= SUM_W'(ceq_pkg::QUEUE_DEPTH)) begin
         scan_addr = ceq_pkg::IDX_W'(scan_sum - SUM_W'(ceq_pkg::QUEUE_DEPTH));
      end else begin
         scan_addr = ceq_pkg::IDX_W'(scan_sum);
      end
   end

   assign rd_addr = cmd.rd_head ? head_ff : scan_addr;
   assign rd_en   = cmd.rd_head || (cmd.scan_step && scan_more);

   // pointer increments
   assign head_next = (head_ff == ceq_pkg::IDX_W'(ceq_pkg::QUEUE_DEPTH - 1)) ? '0
                      : head_ff + 1'b1;
   assign tail_next = (tail_ff == ceq_pkg::IDX_W'(ceq_pkg::QUEUE_DEPTH - 1)) ? '0
                      : tail_ff + 1'b1;

   // commit: state changes and response
   always_comb begin
      do_append   = 1'b0;
      do_coalesce = 1'b0;
      do_take     = 1'b0;
      do_clear    = 1'b0;
      status_in   = ceq_pkg::ST_DONE;
      out_ev_in   = '0;
      out_val_in  = '0;
      out_hdl_in  = '0;
      fin_in      = 1'b0;
      case (op_ff)
         ceq_pkg::OP_POST: begin
            if (!code_ok) begin
               status_in = ceq_pkg::ST_IGNORED;
            end else if (found_ff) begin
               do_coalesce = 1'b1;
               status_in   = ceq_pkg::ST_COALESCED;
            end else if (full) begin
               status_in = ceq_pkg::ST_FULL;
            end else begin
               do_append = 1'b1;
            end
         end
         ceq_pkg::OP_SEND: begin
            if (!code_ok) begin
               status_in = ceq_pkg::ST_IGNORED;
            end else if (full) begin
               status_in = ceq_pkg::ST_FULL;
            end else begin
               do_append = 1'b1;
            end
         end
         ceq_pkg::OP_TAKE: begin
            do_take = 1'b1;
            if (empty) begin
               status_in = ceq_pkg::ST_EMPTY;
            end else begin
               out_ev_in  = rd_ev_ff;
               out_val_in = rd_val_ff;
               out_hdl_in = rd_hdl_ff;
            end
         end
         ceq_pkg::OP_CHECK: begin
            fin_in = (current_ff != code_ff) && !found_ff;
         end
         ceq_pkg::OP_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            status_in = ceq_pkg::ST_IGNORED;
         end
      endcase
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && do_append) begin
         ev_mem[tail_ff] <= code_ff;
      end
      if (cmd.commit && (do_append || do_coalesce)) begin
         val_mem[do_coalesce ? pos_ff : tail_ff] <=
            (op_ff == ceq_pkg::OP_SEND) ? value_ff : '0;
         hdl_mem[do_coalesce ? pos_ff : tail_ff] <=
            (op_ff == ceq_pkg::OP_SEND) ? handle_ff : '0;
      end
      if (rd_en) begin
         rd_ev_ff  <= ev_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
         rd_hdl_ff <= hdl_mem[rd_addr];
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         code_ff   <= req_event_code;
         value_ff  <= req_param_value;
         handle_ff <= req_param_handle;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         out_ev_ff  <= out_ev_in;
         out_val_ff <= out_val_in;
         out_hdl_ff <= out_hdl_in;
         fin_ff     <= fin_in;
      end
      if (cmd.scan_step && stat.match_now) begin
         pos_ff <= cmp_addr_ff;
      end
      if (cmd.scan_step && scan_more) begin
         cmp_addr_ff <= scan_addr;
      end
   end

   // queue pointers, limit and search control
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= ceq_pkg::LIMIT_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         current_ff  <= '0;
         scan_ff     <= '0;
         cmp_pend_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (limit_wr) begin
            limit_ff <= limit_data;
         end
         if (cmd.load) begin
            scan_ff     <= '0;
            cmp_pend_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_pend_ff <= scan_more;
            if (scan_more) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (stat.match_now) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            if (do_append) begin
               tail_ff  <= tail_next;
               count_ff <= count_ff + 1'b1;
            end
            if (do_take) begin
               current_ff <= empty ? '0 : rd_ev_ff;
               if (!empty) begin
                  head_ff  <= head_next;
                  count_ff <= count_ff - 1'b1;
               end
            end
            if (do_clear) begin
               head_ff  <= '0;
               tail_ff  <= '0;
               count_ff <= '0;
            end
         end
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_out_event  = out_ev_ff;
   assign rsp_out_value  = out_val_ff;
   assign rsp_out_handle = out_hdl_ff;
   assign rsp_finished   = fin_ff;

endmodule

// File: rtl/ceq_checker.sv
// port-level checker of the coalescing event queue and its bind to the top level
// depends on ceq_pkg and coalescing_event_queue_top
module ceq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ceq_pkg::STATUS_W-1:0]      rsp_status,
   input logic [ceq_pkg::CODE_W-1:0]        rsp_out_event,
   input logic signed [ceq_pkg::DATA_W-1:0] rsp_out_value,
   input logic [ceq_pkg::DATA_W-1:0]        rsp_out_handle,
   input logic                              rsp_finished
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_event) && $stable(rsp_out_value)
         && $stable(rsp_out_handle) && $stable(rsp_finished))
      else $error("response changed while stalled");

   // one request at a time: busy right after an accepted request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // only a check may answer finished, and it always answers done
   a_finished_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_status == ceq_pkg::ST_DONE
         && rsp_out_event == '0)
      else $error("finished on a response that is not a check");

   // entry fields are zero on a response whose status is not done
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ceq_pkg::ST_DONE |-> rsp_out_event == '0
         && rsp_out_value == '0 && rsp_out_handle == '0)
      else $error("entry fields set on a response without a take");

endmodule

bind coalescing_event_queue_top ceq_checker u_ceq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_out_event  (rsp_out_event),
   .rsp_out_value  (rsp_out_value),
   .rsp_out_handle (rsp_out_handle),
   .rsp_finished   (rsp_finished)
);

// File: bench/testbench.sv
// self-checking bench for coalescing_event_queue_top: directed table, then random requests
// expected responses come from an in-bench queue predictor; needs only rtl/ceq_pkg.sv and the rtl
module testbench;

   // reserved operation codes, ignored by the block
   localparam logic [ceq_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd5;
   localparam logic [ceq_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int PLAN_ROWS       = 27;

   typedef struct packed {
      logic [ceq_pkg::STATUS_W-1:0]      status;
      logic [ceq_pkg::CODE_W-1:0]        code;
      logic signed [ceq_pkg::DATA_W-1:0] value;
      logic [ceq_pkg::DATA_W-1:0]        handle;
      logic                              finished;
   } queue_response_type;

   typedef struct packed {
      logic [ceq_pkg::OP_W-1:0]   op;
      logic [ceq_pkg::CODE_W-1:0] code;
      logic [ceq_pkg::DATA_W-1:0] value;
      logic [ceq_pkg::DATA_W-1:0] handle;
      logic [4:0]                 repeats;
      logic                       typed;
      queue_response_type         answer;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [ceq_pkg::OP_W-1:0]          req_operation = ceq_pkg::OP_POST;
   logic [ceq_pkg::CODE_W-1:0]        req_event_code = '0;
   logic signed [ceq_pkg::DATA_W-1:0] req_param_value = '0;
   logic [ceq_pkg::DATA_W-1:0]        req_param_handle = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [ceq_pkg::STATUS_W-1:0]      rsp_status;
   logic [ceq_pkg::CODE_W-1:0]        rsp_out_event;
   logic signed [ceq_pkg::DATA_W-1:0] rsp_out_value;
   logic [ceq_pkg::DATA_W-1:0]        rsp_out_handle;
   logic                              rsp_finished;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [ceq_pkg::LIMIT_W-1:0]       csr_event_code_limit = ceq_pkg::LIMIT_RESET;

   // mirror of the queue state
   logic [ceq_pkg::CODE_W-1:0]        mirror_code   [ceq_pkg::QUEUE_DEPTH];
   logic signed [ceq_pkg::DATA_W-1:0] mirror_value  [ceq_pkg::QUEUE_DEPTH];
   logic [ceq_pkg::DATA_W-1:0]        mirror_handle [ceq_pkg::QUEUE_DEPTH];
   logic [ceq_pkg::IDX_W-1:0]         mirror_head = '0;
   logic [ceq_pkg::IDX_W-1:0]         mirror_tail = '0;
   logic [ceq_pkg::CNT_W-1:0]         mirror_count = '0;
   logic [ceq_pkg::CODE_W-1:0]        mirror_current = '0;
   logic [ceq_pkg::LIMIT_W-1:0]       mirror_limit = ceq_pkg::LIMIT_RESET;

   queue_response_type pending_responses [$];
   plan_row_type       directed_plan [PLAN_ROWS];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   int                 stall_left = 0;
   int                 stall_mode = 0;

   coalescing_event_queue_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_event_code(req_event_code),
      .req_param_value(req_param_value),
      .req_param_handle(req_param_handle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_event(rsp_out_event),
      .rsp_out_value(rsp_out_value),
      .rsp_out_handle(rsp_out_handle),
      .rsp_finished(rsp_finished),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_event_code_limit(csr_event_code_limit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // queue position holding the code, or -1
   function automatic int find_queued(input logic [ceq_pkg::CODE_W-1:0] code);
      int idx;
      for (int k = 0; k < int'(mirror_count); k++) begin
         idx = (int'(mirror_head) + k) % ceq_pkg::QUEUE_DEPTH;
         if (mirror_code[idx] == code) return idx;
      end
      return -1;
   endfunction

   function automatic logic [ceq_pkg::STATUS_W-1:0] append_entry(
         input logic [ceq_pkg::CODE_W-1:0] code,
         input logic signed [ceq_pkg::DATA_W-1:0] value,
         input logic [ceq_pkg::DATA_W-1:0] handle);
      if (int'(mirror_count) >= ceq_pkg::QUEUE_DEPTH) return ceq_pkg::ST_FULL;
      mirror_code[mirror_tail]   = code;
      mirror_value[mirror_tail]  = value;
      mirror_handle[mirror_tail] = handle;
      mirror_tail  = ceq_pkg::IDX_W'((int'(mirror_tail) + 1) % ceq_pkg::QUEUE_DEPTH);
      mirror_count = mirror_count + 1'b1;
      return ceq_pkg::ST_DONE;
   endfunction

   // applies one request to the mirror and returns the response it gives
   function automatic queue_response_type predict_response(
         input logic [ceq_pkg::OP_W-1:0] op,
         input logic [ceq_pkg::CODE_W-1:0] code,
         input logic signed [ceq_pkg::DATA_W-1:0] value,
         input logic [ceq_pkg::DATA_W-1:0] handle);
      queue_response_type r;
      logic               code_ok;
      int                 hit;
      r = '0;
      r.status = ceq_pkg::ST_DONE;
      code_ok = (code != '0) && ({1'b0, code} < mirror_limit);
      case (op)
         ceq_pkg::OP_POST: begin
            if (!code_ok) begin
               r.status = ceq_pkg::ST_IGNORED;
            end else begin
               hit = find_queued(code);
               if (hit >= 0) begin
                  mirror_value[hit]  = '0;
                  mirror_handle[hit] = '0;
                  r.status = ceq_pkg::ST_COALESCED;
               end else begin
                  r.status = append_entry(code, '0, '0);
               end
            end
         end
         ceq_pkg::OP_SEND: begin
            if (!code_ok) r.status = ceq_pkg::ST_IGNORED;
            else r.status = append_entry(code, value, handle);
         end
         ceq_pkg::OP_TAKE: begin
            mirror_current = '0;
            if (mirror_count == '0) begin
               r.status = ceq_pkg::ST_EMPTY;
            end else begin
               r.code   = mirror_code[mirror_head];
               r.value  = mirror_value[mirror_head];
               r.handle = mirror_handle[mirror_head];
               mirror_current = r.code;
               mirror_head  = ceq_pkg::IDX_W'((int'(mirror_head) + 1) % ceq_pkg::QUEUE_DEPTH);
               mirror_count = mirror_count - 1'b1;
            end
         end
         ceq_pkg::OP_CHECK: r.finished = (mirror_current != code) && (find_queued(code) < 0);
         ceq_pkg::OP_CLEAR: begin
            mirror_head  = '0;
            mirror_tail  = '0;
            mirror_count = '0;
         end
         default: r.status = ceq_pkg::ST_IGNORED;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [ceq_pkg::DATA_W-1:0] got,
         input logic [ceq_pkg::DATA_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // sender pacing: bursts of random length separated by random gaps
   task automatic pace_sender();
      int g;
      int gap;
      if (burst_left == 0) begin
         g = $urandom_range(0, 9);
         gap = (g < 4) ? 0 : (g < 9) ? $urandom_range(1, 5) : $urandom_range(10, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // offers one request, waits for acceptance and records the expected response
   task automatic issue_request(input logic [ceq_pkg::OP_W-1:0] op,
         input logic [ceq_pkg::CODE_W-1:0] code, input logic [ceq_pkg::DATA_W-1:0] value,
         input logic [ceq_pkg::DATA_W-1:0] handle, input logic typed,
         input queue_response_type answer);
      queue_response_type predicted;
      pace_sender();
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_event_code   <= code;
      req_param_value  <= value;
      req_param_handle <= handle;
      do @(posedge clock); while (req_stall);
      predicted = predict_response(op, code, value, handle);
      pending_responses.push_back(typed ? answer : predicted);
   endtask

   // let every outstanding request drain before touching the register
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_code_limit(input logic [ceq_pkg::LIMIT_W-1:0] limit);
      csr_valid            <= 1'b1;
      csr_event_code_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      mirror_limit = limit;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ceq_pkg::OP_W-1:0] pick_reserved_op();
      return ceq_pkg::OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
   endfunction

   // random request: codes mostly from a small hot set so that coalescing and checks hit
   task automatic make_random_request(input int drain_share,
         output logic [ceq_pkg::OP_W-1:0] op, output logic [ceq_pkg::CODE_W-1:0] code,
         output logic [ceq_pkg::DATA_W-1:0] value, output logic [ceq_pkg::DATA_W-1:0] handle);
      int w;
      int hot_top;
      w = $urandom_range(0, 99);
      if (w < 2) op = ceq_pkg::OP_CLEAR;
      else if (w < 5) op = pick_reserved_op();
      else if (w < 20) op = ceq_pkg::OP_CHECK;
      else if (w < 20 + drain_share) op = ceq_pkg::OP_TAKE;
      else if ($urandom_range(0, 1) == 1) op = ceq_pkg::OP_POST;
      else op = ceq_pkg::OP_SEND;
      hot_top = int'(mirror_limit) - 1;
      if (hot_top > 24) hot_top = 24;
      if (hot_top < 1) hot_top = 1;
      if ($urandom_range(0, 9) == 0) code = ceq_pkg::CODE_W'($urandom);
      else code = ceq_pkg::CODE_W'($urandom_range(1, hot_top));
      value  = $urandom;
      handle = $urandom;
   endtask

   // receiver stall pattern: modes of free flow, light, heavy and periodic stalling
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 5) < 2);
      endcase
   end

   // response checker against the oldest expectation
   always @(posedge clock) begin
      queue_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response status %0d with nothing expected", rsp_status));
         end else begin
            want = pending_responses.pop_front();
            compare_field("status", ceq_pkg::DATA_W'(rsp_status), ceq_pkg::DATA_W'(want.status));
            compare_field("out_event", ceq_pkg::DATA_W'(rsp_out_event),
                          ceq_pkg::DATA_W'(want.code));
            compare_field("out_value", rsp_out_value, want.value);
            compare_field("out_handle", rsp_out_handle, want.handle);
            compare_field("finished", ceq_pkg::DATA_W'(rsp_finished),
                          ceq_pkg::DATA_W'(want.finished));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_mismatch($sformatf("timeout with %0d responses outstanding",
                                   pending_responses.size()));
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [ceq_pkg::OP_W-1:0]    op;
      logic [ceq_pkg::CODE_W-1:0]  code;
      logic [ceq_pkg::DATA_W-1:0]  value;
      logic [ceq_pkg::DATA_W-1:0]  handle;
      logic [ceq_pkg::LIMIT_W-1:0] phase_limits [4];
      int                          drain_share;

      // directed requests; typed answers where they are obvious
      directed_plan = '{
         // take and checks straight after reset
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_EMPTY, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd255, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b1}},
         // zero code and reserved operations
         '{ceq_pkg::OP_POST, 8'd0, 32'hffffffff, 32'hffffffff, 5'd1, 1'b1,
           '{ceq_pkg::ST_IGNORED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_SEND, 8'd0, 32'hffffffff, 32'hffffffff, 5'd1, 1'b1,
           '{ceq_pkg::ST_IGNORED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{OP_RESERVED_LO, 8'd255, 32'hffffffff, 32'hffffffff, 5'd1, 1'b1,
           '{ceq_pkg::ST_IGNORED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{OP_RESERVED_HI, 8'd1, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_IGNORED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         // extremes, coalescing and draining
         '{ceq_pkg::OP_SEND, 8'd255, 32'h7fffffff, 32'hffffffff, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_SEND, 8'd1, 32'h80000000, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_POST, 8'd255, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_COALESCED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_POST, 8'd128, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd128, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd255, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd255, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd1, 32'sh80000000, 32'h0, 1'b0}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd128, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_EMPTY, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd255, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b1}},
         // fill the queue, then overflow it
         '{ceq_pkg::OP_SEND, 8'd16, 32'h5a5a0000, 32'ha5a50000, 5'd16, 1'b0, '0},
         '{ceq_pkg::OP_SEND, 8'd200, 32'h1, 32'h1, 5'd1, 1'b1,
           '{ceq_pkg::ST_FULL, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_POST, 8'd100, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_FULL, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_POST, 8'd31, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_COALESCED, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd254, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b1}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b0, '0},
         // clear keeps the current event
         '{ceq_pkg::OP_CLEAR, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_CHECK, 8'd16, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_DONE, 8'd0, 32'sh0, 32'h0, 1'b0}},
         '{ceq_pkg::OP_TAKE, 8'd0, 32'h0, 32'h0, 5'd1, 1'b1,
           '{ceq_pkg::ST_EMPTY, 8'd0, 32'sh0, 32'h0, 1'b0}}
      };
      phase_limits = '{9'd2, ceq_pkg::LIMIT_W'($urandom_range(3, 254)), 9'd255, 9'd256};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table walk
      for (int row = 0; row < PLAN_ROWS; row++) begin
         for (int k = 0; k < int'(directed_plan[row].repeats); k++) begin
            issue_request(directed_plan[row].op,
                          directed_plan[row].code + ceq_pkg::CODE_W'(k),
                          directed_plan[row].value + ceq_pkg::DATA_W'(k),
                          directed_plan[row].handle + ceq_pkg::DATA_W'(k),
                          directed_plan[row].typed, directed_plan[row].answer);
         end
      end

      // random phases, one code limit each
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_code_limit(phase_limits[phase]);
         drain_share = 30;
         for (int issued = 0; issued < ITEMS_PER_PHASE; issued++) begin
            if (issued % 40 == 0) drain_share = 15 * $urandom_range(1, 3);
            make_random_request(drain_share, op, code, value, handle);
            issue_request(op, code, value, handle, 1'b0, '0);
         end
      end

      // drain and finish
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
